[hw/rtl/gdec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdec_pkg: shared types and constants of the gamepad conditioner
//
// Field widths, configuration register indexes and reset values, and the
// packed transaction types of the input and result channels.
// ----------------------------------------------------------------------------
package gdec_pkg;

    // Field widths.
    localparam int BUTTON_BITS = 18;
    localparam int AXIS_BITS   = 16;
    localparam int MASK_W      = BUTTON_BITS + 2;
    localparam int ZONE_W      = AXIS_BITS - 1;
    localparam int TRIG_W      = 16;
    localparam int CFG_DATA_W  = (ZONE_W > TRIG_W) ? ZONE_W : TRIG_W;
    localparam int CFG_ADDR_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_ZONE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_ZONE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIG_THRESH = 2'd2;

    // Reset values: a quarter of full scale for both zones, about 0.1 of
    // full travel for the trigger threshold.
    localparam logic [ZONE_W-1:0] ZONE_RST   = ZONE_W'(1) << (AXIS_BITS - 3);
    localparam logic [TRIG_W-1:0] THRESH_RST = 16'd6554;

    // One controller reading.
    typedef struct packed {
        logic        [BUTTON_BITS-1:0] button_bits;
        logic signed [AXIS_BITS-1:0]   left_x_raw;
        logic signed [AXIS_BITS-1:0]   left_y_raw;
        logic signed [AXIS_BITS-1:0]   right_x_raw;
        logic signed [AXIS_BITS-1:0]   right_y_raw;
        logic        [TRIG_W-1:0]      left_pull;
        logic        [TRIG_W-1:0]      right_pull;
    } in_t;

    // One conditioned result.
    typedef struct packed {
        logic signed [AXIS_BITS-1:0] left_x_out;
        logic signed [AXIS_BITS-1:0] left_y_out;
        logic signed [AXIS_BITS-1:0] right_x_out;
        logic signed [AXIS_BITS-1:0] right_y_out;
        logic        [MASK_W-1:0]    held_mask;
        logic        [MASK_W-1:0]    pressed_mask;
        logic        [MASK_W-1:0]    released_mask;
    } out_t;

endpackage

[hw/rtl/gamepad_deadzone_edge_conditioner_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_deadzone_edge_conditioner_top: radial dead zone and button edges
//
// Conditions one controller reading per transaction. Each stick gets a
// scaled radial dead zone, the triggers become two extra button bits, and
// the button state is compared with the previous reading.
// ----------------------------------------------------------------------------
// A reading is taken when s_valid and s_ready are both high; s_ready is high
// only while the block is idle, and a finished result may still wait in the
// output register while the next reading is taken. Each stick runs through
// one shared subtract-and-shift unit that does a 16-step square root, a
// 16-step division for the normalized magnitude and two 16-step divisions
// for the axis outputs, with a shared 16x16 multiplier for the squares and
// the scale products. A stick inside its dead zone skips the divisions; a
// capped magnitude skips the first division. Configuration writes (cfg_we,
// cfg_addr, cfg_wdata) take effect at once and must be made while the block
// is idle; writes to an unknown index are ignored.
// ----------------------------------------------------------------------------
module gamepad_deadzone_edge_conditioner_top
    import gdec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int A     = AXIS_BITS;
    localparam int SQ_W  = 2 * A;
    localparam int UW    = A + 3;
    localparam int CNT_W = $clog2(A);
    localparam logic [A-1:0]     ONE      = {1'b1, {(A-1){1'b0}}};
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(A - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_ZONE,
        ST_NDIV,
        ST_MULX,
        ST_DIVX,
        ST_MULY,
        ST_DIVY,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic               stick_reg;
    in_t                in_reg;
    logic [MASK_W-1:0]  held_reg;
    logic [MASK_W-1:0]  prev_mask_reg;
    logic [ZONE_W-1:0]  left_zone_reg;
    logic [ZONE_W-1:0]  right_zone_reg;
    logic [TRIG_W-1:0]  thresh_reg;

    logic [SQ_W-1:0]    sq_reg;
    logic [SQ_W-1:0]    dv_reg;
    logic [UW-1:0]      rem_reg;
    logic [A-1:0]       q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [A-1:0]       div_reg;
    logic [A-1:0]       mag_reg;
    logic [A-1:0]       norm_reg;

    logic [A-1:0]       lx_out_reg;
    logic [A-1:0]       ly_out_reg;
    logic [A-1:0]       rx_out_reg;
    logic [A-1:0]       ry_out_reg;
    out_t               m_data_reg;
    logic               m_valid_reg;

    // Apply the input sign to a quotient magnitude and saturate +1.0.
    function automatic logic [A-1:0] apply_sign(input logic [A-1:0] mag_q,
                                                input logic         neg);
        logic [A-1:0] res;
        if (neg) begin
            res = -mag_q;
        end else if (mag_q >= ONE) begin
            res = ONE - A'(1);
        end else begin
            res = mag_q;
        end
        return res;
    endfunction

    // Operands of the stick being worked on.
    logic [A-1:0]      x_raw;
    logic [A-1:0]      y_raw;
    logic [A-1:0]      abs_x;
    logic [A-1:0]      abs_y;
    logic [A-1:0]      zone_ext;

    always_comb begin
        x_raw    = stick_reg ? in_reg.right_x_raw : in_reg.left_x_raw;
        y_raw    = stick_reg ? in_reg.right_y_raw : in_reg.left_y_raw;
        abs_x    = x_raw[A-1] ? -x_raw : x_raw;
        abs_y    = y_raw[A-1] ? -y_raw : y_raw;
        zone_ext = {1'b0, (stick_reg ? right_zone_reg : left_zone_reg)};
    end

    // Shared multiplier: squares first, then the scale products.
    logic [A-1:0]    mul_a;
    logic [A-1:0]    mul_b;
    logic [SQ_W-1:0] prod;

    always_comb begin
        case (state_reg)
            ST_SQX: begin
                mul_a = abs_x;
                mul_b = abs_x;
            end
            ST_SQY: begin
                mul_a = abs_y;
                mul_b = abs_y;
            end
            ST_MULX: begin
                mul_a = abs_x;
                mul_b = norm_reg;
            end
            ST_MULY: begin
                mul_a = abs_y;
                mul_b = norm_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Shared subtract-and-shift unit. The square root brings down two bits
    // per step and tries 4*root+1; a division brings down one bit and tries
    // the divisor.
    logic            sqrt_mode;
    logic [UW-1:0]   shifted;
    logic [UW-1:0]   trial;
    logic            ge;
    logic [UW-1:0]   rem_next;
    logic [A-1:0]    q_next;
    logic [SQ_W-1:0] dv_next;
    logic            last_step;

    always_comb begin
        sqrt_mode = (state_reg == ST_SQRT);
        if (sqrt_mode) begin
            shifted = {rem_reg[UW-3:0], dv_reg[SQ_W-1 -: 2]};
            trial   = UW'({q_reg, 2'b01});
            dv_next = dv_reg << 2;
        end else begin
            shifted = {rem_reg[UW-2:0], dv_reg[SQ_W-1]};
            trial   = UW'(div_reg);
            dv_next = dv_reg << 1;
        end
        ge        = (shifted >= trial);
        rem_next  = ge ? (shifted - trial) : shifted;
        q_next    = {q_reg[A-2:0], ge};
        last_step = (cnt_reg == LAST_CNT);
    end

    // Dead-zone decision and first remainder of the normalizing division.
    logic [A-1:0] mag_minus_z;
    logic [A-1:0] one_minus_z;
    logic         in_zone;
    logic         norm_cap;

    always_comb begin
        mag_minus_z = mag_reg - zone_ext;
        one_minus_z = ONE - zone_ext;
        in_zone     = (mag_reg < zone_ext) || (mag_reg == '0);
        norm_cap    = ((mag_minus_z >> 1) >= one_minus_z);
    end

    // Sequencer, configuration registers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            stick_reg      <= 1'b0;
            prev_mask_reg  <= '0;
            left_zone_reg  <= ZONE_RST;
            right_zone_reg <= ZONE_RST;
            thresh_reg     <= THRESH_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_LEFT_ZONE:   left_zone_reg  <= cfg_wdata[ZONE_W-1:0];
                    CFG_RIGHT_ZONE:  right_zone_reg <= cfg_wdata[ZONE_W-1:0];
                    CFG_TRIG_THRESH: thresh_reg     <= cfg_wdata[TRIG_W-1:0];
                    default: ;
                endcase
            end

            // In ST_DONE a leaving result is replaced by the new one below.
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        held_reg  <= {(s_data.right_pull > thresh_reg),
                                      (s_data.left_pull > thresh_reg),
                                      s_data.button_bits};
                        stick_reg <= 1'b0;
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX: begin
                    sq_reg    <= prod;
                    state_reg <= ST_SQY;
                end
                ST_SQY: begin
                    dv_reg    <= sq_reg + prod;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    dv_reg  <= dv_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (last_step) begin
                        mag_reg   <= q_next;
                        state_reg <= ST_ZONE;
                    end
                end
                ST_ZONE: begin
                    if (in_zone) begin
                        if (stick_reg) begin
                            rx_out_reg <= '0;
                            ry_out_reg <= '0;
                            state_reg  <= ST_DONE;
                        end else begin
                            lx_out_reg <= '0;
                            ly_out_reg <= '0;
                            stick_reg  <= 1'b1;
                            state_reg  <= ST_SQX;
                        end
                    end else if (norm_cap) begin
                        norm_reg  <= ONE;
                        state_reg <= ST_MULX;
                    end else begin
                        rem_reg   <= UW'(mag_minus_z >> 1);
                        dv_reg    <= {mag_minus_z[0], {(SQ_W-1){1'b0}}};
                        div_reg   <= one_minus_z;
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_NDIV;
                    end
                end
                ST_NDIV: begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    dv_reg  <= dv_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (last_step) begin
                        norm_reg  <= (q_next > ONE) ? ONE : q_next;
                        state_reg <= ST_MULX;
                    end
                end
                ST_MULX, ST_MULY: begin
                    rem_reg   <= UW'(prod[SQ_W-1:A]);
                    dv_reg    <= {prod[A-1:0], {A{1'b0}}};
                    div_reg   <= mag_reg;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= (state_reg == ST_MULX) ? ST_DIVX : ST_DIVY;
                end
                ST_DIVX: begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    dv_reg  <= dv_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (last_step) begin
                        if (stick_reg) begin
                            rx_out_reg <= apply_sign(q_next, x_raw[A-1]);
                        end else begin
                            lx_out_reg <= apply_sign(q_next, x_raw[A-1]);
                        end
                        state_reg <= ST_MULY;
                    end
                end
                ST_DIVY: begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    dv_reg  <= dv_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (last_step) begin
                        if (stick_reg) begin
                            ry_out_reg <= apply_sign(q_next, y_raw[A-1]);
                            state_reg  <= ST_DONE;
                        end else begin
                            ly_out_reg <= apply_sign(q_next, y_raw[A-1]);
                            stick_reg  <= 1'b1;
                            state_reg  <= ST_SQX;
                        end
                    end
                end
                ST_DONE: begin
                    // Wait for the output register to be free.
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.left_x_out    <= lx_out_reg;
                        m_data_reg.left_y_out    <= ly_out_reg;
                        m_data_reg.right_x_out   <= rx_out_reg;
                        m_data_reg.right_y_out   <= ry_out_reg;
                        m_data_reg.held_mask     <= held_reg;
                        m_data_reg.pressed_mask  <= held_reg & ~prev_mask_reg;
                        m_data_reg.released_mask <= ~held_reg & prev_mask_reg;
                        prev_mask_reg            <= held_reg;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A division step never starts with a remainder at or above the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NDIV || state_reg == ST_DIVX || state_reg == ST_DIVY)
        |-> (rem_reg < UW'(div_reg)))
        else $error("division remainder not below divisor");

    // The stored previous mask always matches the result on offer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (prev_mask_reg == m_data_reg.held_mask))
        else $error("previous mask out of step with result");

    // A button cannot be pressed and released in the same reading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.pressed_mask & m_data_reg.released_mask) == '0))
        else $error("pressed and released masks overlap");

    // An accepted reading starts with the left stick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SQX && !stick_reg))
        else $error("reading not started on the left stick");

endmodule
